/* src/ntx_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntx_pkg
// Shared types and codes for the number token extractor: parse phases,
// stop codes, character constants and the configuration bundle.
// ============================================================================
package ntx_pkg;

    localparam int DEF_MAX_CHARS = 64;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SIGN   = 4'd1;
    localparam logic [3:0] PH_INT    = 4'd2;
    localparam logic [3:0] PH_FRAC   = 4'd3;
    localparam logic [3:0] PH_EMARK  = 4'd4;
    localparam logic [3:0] PH_EXP    = 4'd5;
    localparam logic [3:0] PH_POSTIM = 4'd6;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_SEP = 2'd1;
    localparam logic [1:0] ST_ILL = 2'd2;
    localparam logic [1:0] ST_END = 2'd3;

    localparam logic [1:0] REG_POINT_IS_PERIOD  = 2'd0;
    localparam logic [1:0] REG_GROUPING_ENABLED = 2'd1;
    localparam logic [1:0] REG_REAL_ONLY        = 2'd2;

    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_0     = 8'h30;
    localparam logic [7:0] C_1     = 8'h31;
    localparam logic [7:0] C_9     = 8'h39;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_UE    = 8'h45;
    localparam logic [7:0] C_LE    = 8'h65;
    localparam logic [7:0] C_I     = 8'h69;
    localparam logic [7:0] C_SPACE = 8'h20;

    typedef struct packed {
        logic point_is_period;
        logic grouping_enabled;
        logic real_only;
    } t_cfg;

endpackage

/* src/ntx_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntx_front
// Per-character parse step: classifies the character, updates the parse
// state and hands a job of up to two output characters to the queue.
// ============================================================================
module ntx_front
    import ntx_pkg::*;
#(
    parameter int  MAX_CHARS = DEF_MAX_CHARS,
    parameter int  CW        = $clog2(MAX_CHARS + 1),
    parameter type t_job     = logic
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    input  logic       i_restart,
    input  logic       i_last,
    input  logic       i_q_ready,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    logic [3:0]    r_phase, n_phase;
    logic [CW-1:0] r_dig, n_dig;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_imag, n_imag;
    logic          r_halted, n_halted;

    logic          w_step;
    logic [1:0]    w_status;
    logic [CW-1:0] w_pos;
    logic [1:0]    w_n;
    logic [7:0]    w_c0, w_c1;

    assign o_ready = i_q_ready;
    assign w_step  = i_valid && i_q_ready && !(r_halted && !i_restart);
    assign o_push  = w_step;

    always_comb begin
        logic [3:0]    p;
        logic [CW-1:0] dig, len, idx;
        logic          im, hlt, act, cd, a0, a1;
        logic [1:0]    stop, e_n;
        logic [7:0]    e0, e1, dot, grp;

        p    = i_restart ? PH_IDLE : r_phase;
        dig  = i_restart ? '0 : r_dig;
        len  = i_restart ? '0 : r_len;
        idx  = i_restart ? '0 : r_idx;
        im   = i_restart ? 1'b0 : r_imag;
        hlt  = 1'b0;
        dot  = i_cfg.point_is_period ? C_DOT : C_COMMA;
        grp  = i_cfg.point_is_period ? C_COMMA : C_DOT;
        act  = (p == PH_INT) || (p == PH_FRAC) || (p == PH_EXP);
        n_phase = p;
        stop = ST_RUN;
        e_n  = 2'd0;
        e0   = 8'h00;
        e1   = 8'h00;
        cd   = 1'b0;
        n_imag = im;
        w_status = ST_RUN;
        w_pos    = '0;

        if (i_ch == C_PLUS || i_ch == C_MINUS) begin
            if (p == PH_IDLE) begin
                if (i_ch == C_MINUS) begin
                    e_n = 2'd1;
                    e0  = i_ch;
                end
                n_phase = PH_SIGN;
            end else if (act || p == PH_POSTIM) begin
                stop = ST_SEP;
            end else if (p == PH_EMARK) begin
                if (i_ch == C_MINUS) begin
                    e_n = 2'd1;
                    e0  = i_ch;
                end
                n_phase = PH_EXP;
            end else begin
                stop = ST_ILL;
            end
        end else if (i_ch >= C_0 && i_ch <= C_9) begin
            if (p == PH_IDLE || p == PH_SIGN || act) begin
                if (p == PH_IDLE || p == PH_SIGN) n_phase = PH_INT;
                e_n = 2'd1;
                e0  = i_ch;
                cd  = 1'b1;
            end else if (p == PH_EMARK) begin
                e_n = 2'd1;
                e0  = i_ch;
                cd  = 1'b1;
                n_phase = PH_EXP;
            end else begin
                stop = ST_ILL;
            end
        end else if (i_cfg.grouping_enabled && i_ch == grp) begin
            if (p != PH_INT) stop = ST_ILL;
        end else if (i_ch == C_DOT || i_ch == C_COMMA) begin
            if (p == PH_IDLE || p == PH_SIGN) begin
                e_n = 2'd2;
                e0  = C_0;
                e1  = dot;
                n_phase = PH_FRAC;
            end else if (p == PH_INT) begin
                e_n = 2'd1;
                e0  = dot;
                n_phase = PH_FRAC;
            end else begin
                stop = ST_ILL;
            end
        end else if (i_ch == C_UE || i_ch == C_LE) begin
            if (p == PH_SIGN) begin
                e_n = 2'd2;
                e0  = C_1;
                e1  = C_LE;
                cd  = 1'b1;
                n_phase = PH_EMARK;
            end else if (p == PH_INT || p == PH_FRAC) begin
                e_n = 2'd1;
                e0  = C_LE;
                n_phase = PH_EMARK;
            end else begin
                stop = ST_ILL;
            end
        end else if (i_ch == C_I && !i_cfg.real_only) begin
            if (p == PH_IDLE || p == PH_SIGN) begin
                n_imag  = 1'b1;
                n_phase = PH_INT;
            end else if (act) begin
                n_imag  = 1'b1;
                n_phase = PH_POSTIM;
            end else begin
                stop = ST_ILL;
            end
        end else if (i_ch == C_SPACE) begin
            if (p == PH_IDLE || p == PH_SIGN) begin
                n_phase = p;
            end else if (act || p == PH_POSTIM) begin
                stop = ST_SEP;
            end else begin
                stop = ST_ILL;
            end
        end else if (p != PH_IDLE) begin
            stop = ST_ILL;
        end

        if (stop != ST_RUN) begin
            if (dig == '0 && n_imag) begin
                e_n = 2'd1;
                e0  = C_1;
                cd  = 1'b1;
                hlt = 1'b1;
                w_status = stop;
                w_pos    = idx;
            end else if (dig == '0) begin
                n_phase = PH_IDLE;
            end else begin
                hlt = 1'b1;
                w_status = stop;
                w_pos    = idx;
            end
        end

        // emitted characters are dropped once the buffer is full
        a0 = (e_n != 2'd0) && (len < CW'(MAX_CHARS));
        a1 = (e_n == 2'd2) && (len < CW'(MAX_CHARS - 1));
        w_n  = a1 ? 2'd2 : (a0 ? 2'd1 : 2'd0);
        w_c0 = e0;
        w_c1 = e1;
        n_len = len + CW'(w_n);
        n_dig = (cd && dig < CW'(MAX_CHARS)) ? dig + CW'(1) : dig;
        n_idx = (idx < CW'(MAX_CHARS)) ? idx + CW'(1) : idx;

        if (!hlt && i_last) begin
            hlt = 1'b1;
            w_status = ST_END;
            w_pos    = n_idx;
        end
        n_halted = hlt;
    end

    always_comb begin
        o_job        = '0;
        o_job.n      = w_n;
        o_job.c0     = w_c0;
        o_job.c1     = w_c1;
        o_job.status = w_status;
        o_job.pos    = w_pos;
        o_job.dig    = n_dig;
        o_job.len    = n_len;
        o_job.imag   = n_imag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_dig    <= '0;
            r_len    <= '0;
            r_idx    <= '0;
            r_imag   <= 1'b0;
            r_halted <= 1'b0;
        end else if (w_step) begin
            r_phase  <= n_phase;
            r_dig    <= n_dig;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_imag   <= n_imag;
            r_halted <= n_halted;
        end
    end

endmodule

/* src/ntx_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntx_queue
// Two-entry job queue between the parse front and the output back.
// ============================================================================
module ntx_queue
    import ntx_pkg::*;
#(
    parameter type t_job = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

/* src/ntx_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntx_back
// Output side: splits each job into one or two result beats and holds
// them in the output register until taken.
// ============================================================================
module ntx_back
    import ntx_pkg::*;
#(
    parameter int  CW    = 7,
    parameter int  OUT_W = 32,
    parameter type t_job = logic
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [OUT_W-1:0] o_tdata,
    output logic             o_tlast,
    output logic             o_tuser
);

    localparam int OUT_BITS = 8 + 2 + 3 * CW + 1;

    logic                r_valid;
    logic                r_second;
    logic [OUT_W-1:0]    r_data;
    logic                r_last;
    logic                r_user;
    logic                w_load;
    logic [7:0]          w_char;
    logic [OUT_BITS-1:0] w_payload;

    assign w_load    = !r_valid || i_tready;
    assign w_char    = r_second ? i_job.c1 : ((i_job.n != 2'd0) ? i_job.c0 : 8'h00);
    assign w_payload = {i_job.imag, i_job.len, i_job.dig, i_job.pos, i_job.status, w_char};
    assign o_pop     = w_load && i_q_valid && (r_second || i_job.n != 2'd2);

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;
    assign o_tuser  = r_user;

    always_ff @(posedge i_clk) begin
        if (w_load && i_q_valid) begin
            r_data <= OUT_W'(w_payload);
            r_user <= (i_job.n != 2'd0);
            r_last <= r_second || (i_job.n != 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_second <= !r_second && (i_job.n == 2'd2);
            end
        end
    end

endmodule

/* src/number_token_extractor_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// number_token_extractor_unit
// Number-recognition state machine over a character stream, emitting the
// normalised numeric substring one character per result beat.
// ============================================================================
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------
//  s (char) | in  | i_s_tvalid/o_s_tready| ch; tuser restart; tlast last char
//  m (res)  | out | o_m_tvalid/i_m_tready| char..flags; tuser char_valid;
//           |     |                      | tlast last result of the character
//  cfg      | in  | i_cfg_valid/         | register index, one data bit
//           |     |   o_cfg_ready        |
//
//  One character per cycle into the parse front while the job queue has room;
//  a character yielding two output characters occupies the output register
//  for two result beats. Each job passes through the queue and the output register.
//  The two-entry job queue lets the front keep accepting while the output
//  is stalled; it stops only when the queue is full.
//  Reset (synchronous, active low) clears parse state, queue and config.
//  A halted parse accepts characters without producing beats until restart.
// ============================================================================
module number_token_extractor_unit
    import ntx_pkg::*;
#(
    parameter int MAX_CHARS = DEF_MAX_CHARS,
    parameter int CW        = $clog2(MAX_CHARS + 1),
    parameter int OUT_W     = ((8 + 2 + 3 * CW + 1 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,  // [7:0] ch
    input  logic             i_s_tlast,
    input  logic             i_s_tuser,  // [0] restart
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,  // out_char, status, stop_position,
                                         // digit_count, out_length, is_imag
    output logic             o_m_tlast,
    output logic             o_m_tuser,  // [0] char_valid
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic             i_cfg_data
);

    typedef struct packed {
        logic [1:0]    n;
        logic [7:0]    c0;
        logic [7:0]    c1;
        logic [1:0]    status;
        logic [CW-1:0] pos;
        logic [CW-1:0] dig;
        logic [CW-1:0] len;
        logic          imag;
    } t_job;

    t_cfg r_cfg;
    logic w_q_ready, w_push, w_pop, w_q_valid;
    t_job w_push_job, w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_is_period  <= 1'b1;
            r_cfg.grouping_enabled <= 1'b0;
            r_cfg.real_only        <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POINT_IS_PERIOD:  r_cfg.point_is_period  <= i_cfg_data;
                REG_GROUPING_ENABLED: r_cfg.grouping_enabled <= i_cfg_data;
                REG_REAL_ONLY:        r_cfg.real_only        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ntx_front #(
        .MAX_CHARS(MAX_CHARS),
        .CW       (CW),
        .t_job    (t_job)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .i_ch     (i_s_tdata),
        .i_restart(i_s_tuser),
        .i_last   (i_s_tlast),
        .i_q_ready(w_q_ready),
        .o_ready  (o_s_tready),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    ntx_queue #(
        .t_job(t_job)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_push_job),
        .o_ready(w_q_ready),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_job  (w_head)
    );

    ntx_back #(
        .CW   (CW),
        .OUT_W(OUT_W),
        .t_job(t_job)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_job    (w_head),
        .o_pop    (w_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast),
        .o_tuser  (o_m_tuser)
    );

endmodule

/* src/ntx_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// ntx_checker
// Port-level checks on the result stream of the number token extractor.
// ============================================================================
module ntx_checker
    import ntx_pkg::*;
#(
    parameter int MAX_CHARS = DEF_MAX_CHARS,
    parameter int CW        = $clog2(MAX_CHARS + 1),
    parameter int OUT_W     = ((8 + 2 + 3 * CW + 1 + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata,
    input logic             o_m_tlast,
    input logic             o_m_tuser
);

    logic [1:0]    w_status;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_len;

    assign w_status = o_m_tdata[9:8];
    assign w_pos    = o_m_tdata[10 +: CW];
    assign w_len    = o_m_tdata[10 + 2 * CW +: CW];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast)
        else $error("beat without character is not the last of its step");

    a_pair_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser)
        else $error("first beat of a pair carries no character");

    a_run_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_status == ST_RUN |-> w_pos == '0 && w_len <= CW'(MAX_CHARS))
        else $error("running status with a stop position or length overflow");

endmodule

bind number_token_extractor_unit ntx_checker #(
    .MAX_CHARS(MAX_CHARS),
    .CW       (CW),
    .OUT_W    (OUT_W)
) u_ntx_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tlast (o_m_tlast),
    .o_m_tuser (o_m_tuser)
);

/* sim/number_token_extractor_unit_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// number_token_extractor_unit_tb
// Self-checking bench for the number token extractor. Character beats are
// drawn from a queue and driven with random gaps. Each accepted character
// runs through a local model of the parser, which queues the expected result
// beats. The result side stalls at random, and once holds off long enough
// for the unit to back up. Every result beat is checked field by field. The
// run goes through several register settings, written while the unit idles.
// ============================================================================
module number_token_extractor_unit_tb;
    import ntx_pkg::*;

    localparam int MAX_CHARS   = DEF_MAX_CHARS;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 150;
    localparam int PHASE_ITEMS = 175;

    typedef struct {
        logic [7:0] ch;
        logic       restart;
        logic       last;
    } t_char_item;

    typedef struct {
        logic [7:0] chr;
        logic       vld;
        logic       lst;
        logic [1:0] stat;
        logic [6:0] pos;
        logic [6:0] digs;
        logic [6:0] len;
        logic       imag;
    } t_result_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tlast   = 1'b0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = REG_POINT_IS_PERIOD;
    logic        i_cfg_data  = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;
    logic        o_cfg_ready;

    number_token_extractor_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_char_item   char_q[$];
    t_result_beat expected_beats[$];
    int           n_items    = 0;
    int           n_fail     = 0;
    int           beats_seen = 0;

    // parser mirror
    t_cfg       cfg_now = 3'b100;
    logic [3:0] ph_state;
    logic [6:0] n_digits;
    logic [6:0] n_emitted;
    logic       imag_flag;
    logic [6:0] char_pos;
    logic       parse_halted;
    logic [7:0] emit_buf [2];
    int         emit_n;

    task automatic clear_parse();
        ph_state     = PH_IDLE;
        n_digits     = '0;
        n_emitted    = '0;
        imag_flag    = 1'b0;
        char_pos     = '0;
        parse_halted = 1'b0;
    endtask

    task automatic emit_char(input logic [7:0] c);
        if (n_emitted < MAX_CHARS && emit_n < 2) begin
            emit_buf[emit_n] = c;
            emit_n++;
            n_emitted++;
        end
    endtask

    task automatic count_digit();
        if (n_digits < MAX_CHARS)
            n_digits++;
    endtask

    function automatic logic in_number(input logic [3:0] p);
        return p == PH_INT || p == PH_FRAC || p == PH_EXP;
    endfunction

    task automatic extract_step(input logic [7:0] c, input logic rs, input logic lc);
        logic [3:0]   p;
        logic [1:0]   stop;
        logic [1:0]   stat;
        logic [6:0]   pos;
        logic [7:0]   dmark;
        logic [7:0]   gmark;
        t_result_beat r;
        int           n;
        if (rs)
            clear_parse();
        if (parse_halted)
            return;
        emit_n = 0;
        p      = ph_state;
        stop   = ST_RUN;
        stat   = ST_RUN;
        pos    = '0;
        dmark  = cfg_now.point_is_period ? C_DOT : C_COMMA;
        gmark  = cfg_now.point_is_period ? C_COMMA : C_DOT;

        if (c == C_PLUS || c == C_MINUS) begin
            if (p == PH_IDLE) begin
                if (c == C_MINUS) emit_char(c);
                p = PH_SIGN;
            end else if (in_number(p) || p == PH_POSTIM) begin
                stop = ST_SEP;
            end else if (p == PH_EMARK) begin
                if (c == C_MINUS) emit_char(c);
                p = PH_EXP;
            end else begin
                stop = ST_ILL;
            end
        end else if (c >= C_0 && c <= C_9) begin
            if (p == PH_IDLE || p == PH_SIGN || in_number(p)) begin
                if (p == PH_IDLE || p == PH_SIGN) p = PH_INT;
                emit_char(c);
                count_digit();
            end else if (p == PH_EMARK) begin
                emit_char(c);
                count_digit();
                p = PH_EXP;
            end else begin
                stop = ST_ILL;
            end
        end else if (cfg_now.grouping_enabled && c == gmark) begin
            if (p != PH_INT) stop = ST_ILL;
        end else if (c == C_DOT || c == C_COMMA) begin
            if (p == PH_IDLE || p == PH_SIGN || p == PH_INT) begin
                if (p != PH_INT) emit_char(C_0);
                emit_char(dmark);
                p = PH_FRAC;
            end else begin
                stop = ST_ILL;
            end
        end else if (c == C_UE || c == C_LE) begin
            if (p == PH_SIGN || p == PH_INT || p == PH_FRAC) begin
                if (p == PH_SIGN) begin
                    emit_char(C_1);
                    count_digit();
                end
                emit_char(C_LE);
                p = PH_EMARK;
            end else begin
                stop = ST_ILL;
            end
        end else if (c == C_I && !cfg_now.real_only) begin
            if (p == PH_IDLE || p == PH_SIGN) begin
                imag_flag = 1'b1;
                p = PH_INT;
            end else if (in_number(p)) begin
                imag_flag = 1'b1;
                p = PH_POSTIM;
            end else begin
                stop = ST_ILL;
            end
        end else if (c == C_SPACE) begin
            if (in_number(p) || p == PH_POSTIM)
                stop = ST_SEP;
            else if (p != PH_IDLE && p != PH_SIGN)
                stop = ST_ILL;
        end else if (p != PH_IDLE) begin
            stop = ST_ILL;
        end

        if (stop != ST_RUN) begin
            if (n_digits == 0 && imag_flag) begin
                // lone i stands for 1i
                emit_char(C_1);
                count_digit();
                parse_halted = 1'b1;
                stat = stop;
                pos  = char_pos;
            end else if (n_digits == 0) begin
                p = PH_IDLE;
            end else begin
                parse_halted = 1'b1;
                stat = stop;
                pos  = char_pos;
            end
        end
        ph_state = p;

        if (char_pos < MAX_CHARS)
            char_pos++;
        if (!parse_halted && lc) begin
            parse_halted = 1'b1;
            stat = ST_END;
            pos  = char_pos;
        end

        n = emit_n > 0 ? emit_n : 1;
        for (int k = 0; k < n; k++) begin
            r.chr  = emit_n > 0 ? emit_buf[k] : 8'h00;
            r.vld  = emit_n > 0;
            r.lst  = k == n - 1;
            r.stat = stat;
            r.pos  = pos;
            r.digs = n_digits;
            r.len  = n_emitted;
            r.imag = imag_flag;
            expected_beats.push_back(r);
        end
    endtask

    task automatic report_bad(input string msg);
        n_fail++;
        $display("[%0t] error: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input int idx);
        if (got !== want)
            report_bad($sformatf("beat %0d %s got %0d want %0d", idx, name, got, want));
    endtask

    task automatic check_beat();
        t_result_beat e;
        if (expected_beats.size() == 0) begin
            report_bad($sformatf("unexpected beat %0d tdata %h", beats_seen, o_m_tdata));
        end else begin
            e = expected_beats.pop_front();
            cmp_field("out_char",      32'(o_m_tdata[7:0]),   32'(e.chr),  beats_seen);
            cmp_field("char_valid",    32'(o_m_tuser),        32'(e.vld),  beats_seen);
            cmp_field("last_result",   32'(o_m_tlast),        32'(e.lst),  beats_seen);
            cmp_field("status",        32'(o_m_tdata[9:8]),   32'(e.stat), beats_seen);
            cmp_field("stop_position", 32'(o_m_tdata[16:10]), 32'(e.pos),  beats_seen);
            cmp_field("digit_count",   32'(o_m_tdata[23:17]), 32'(e.digs), beats_seen);
            cmp_field("out_length",    32'(o_m_tdata[30:24]), 32'(e.len),  beats_seen);
            cmp_field("is_imag",       32'(o_m_tdata[31]),    32'(e.imag), beats_seen);
        end
        beats_seen++;
    endtask

    // mostly short gaps, a few long, with calm stretches of none
    function automatic int draw_gap(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // char side
    int s_gap  = 0;
    int s_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            s_gap      <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                extract_step(i_s_tdata, i_s_tuser, i_s_tlast);
            if (!i_s_tvalid || o_s_tready) begin
                if (s_gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    s_gap      <= s_gap - 1;
                end else if (char_q.size() != 0) begin
                    i_s_tdata  <= char_q[0].ch;
                    i_s_tuser  <= char_q[0].restart;
                    i_s_tlast  <= char_q[0].last;
                    i_s_tvalid <= 1'b1;
                    void'(char_q.pop_front());
                    s_gap      <= draw_gap(s_calm);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    int   m_gap     = 0;
    int   m_calm    = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            m_gap      <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                check_beat();
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left  <= hold_left - 1;
            end else if (!hold_done && beats_seen >= HOLD_AT) begin
                i_m_tready <= 1'b0;
                hold_left  <= HOLD_LEN;
                hold_done  <= 1'b1;
            end else if (m_gap > 0) begin
                i_m_tready <= 1'b0;
                m_gap      <= m_gap - 1;
            end else begin
                i_m_tready <= 1'b1;
                m_gap      <= draw_gap(m_calm);
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] error: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("number_token_extractor_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_char(input logic [7:0] c, input logic rs, input logic lc);
        t_char_item it;
        it.ch      = c;
        it.restart = rs;
        it.last    = lc;
        char_q.push_back(it);
        n_items++;
    endtask

    task automatic push_str(input string s, input logic rs, input logic lc);
        for (int k = 0; k < s.len(); k++)
            queue_char(s[k], rs && k == 0, lc && k == s.len() - 1);
    endtask

    function automatic logic [7:0] digit_char();
        return C_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] mark_char();
        return $urandom_range(0, 1) ? C_DOT : C_COMMA;
    endfunction

    function automatic logic [7:0] junk_char();
        case ($urandom_range(0, 9))
            0: return C_SPACE;
            1: return C_I;
            2: return C_LE;
            3: return C_UE;
            4: return C_PLUS;
            5: return C_MINUS;
            6: return mark_char();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_text();
        logic [7:0] t[$];
        int         nd;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 10)) t.push_back(junk_char());
        end else begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) t.push_back(junk_char());
            case ($urandom_range(0, 3))
                0: t.push_back(C_PLUS);
                1: t.push_back(C_MINUS);
                default: ;
            endcase
            nd = ($urandom_range(0, 49) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 7);
            for (int k = 0; k < nd; k++) begin
                if (k > 0 && $urandom_range(0, 5) == 0)
                    t.push_back(mark_char());
                t.push_back(digit_char());
            end
            if ($urandom_range(0, 1)) begin
                t.push_back(mark_char());
                repeat ($urandom_range(0, 4)) t.push_back(digit_char());
            end
            if ($urandom_range(0, 3) == 0) begin
                t.push_back($urandom_range(0, 1) ? C_LE : C_UE);
                case ($urandom_range(0, 2))
                    0: t.push_back(C_PLUS);
                    1: t.push_back(C_MINUS);
                    default: ;
                endcase
                repeat ($urandom_range(0, 3)) t.push_back(digit_char());
            end
            if ($urandom_range(0, 4) == 0)
                t.push_back(C_I);
            case ($urandom_range(0, 5))
                0: t.push_back(C_SPACE);
                1: t.push_back(C_PLUS);
                2: t.push_back(C_MINUS);
                3: t.push_back(junk_char());
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) t.push_back(junk_char());
        end
        for (int k = 0; k < t.size(); k++)
            queue_char(t[k], k == 0 && $urandom_range(0, 9) != 0,
                       k == t.size() - 1 && $urandom_range(0, 4) != 0);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic v);
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_POINT_IS_PERIOD:  cfg_now.point_is_period  = v;
            REG_GROUPING_ENABLED: cfg_now.grouping_enabled = v;
            REG_REAL_ONLY:        cfg_now.real_only        = v;
            default: ;
        endcase
    endtask

    task automatic write_cfg(input t_cfg c);
        i_cfg_valid <= 1'b1;
        put_reg(REG_POINT_IS_PERIOD,  c.point_is_period);
        put_reg(REG_GROUPING_ENABLED, c.grouping_enabled);
        put_reg(REG_REAL_ONLY,        c.real_only);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (char_q.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        // halted characters leave no beat; let the pipe empty
        repeat (8) @(posedge i_clk);
    endtask

    t_cfg cfg_plan [6];

    initial begin
        cfg_plan[0] = 3'b100;
        cfg_plan[1] = 3'b010;
        cfg_plan[2] = 3'b111;
        cfg_plan[3] = 3'b001;
        cfg_plan[4] = 3'b110;
        cfg_plan[5] = 3'b011;
        clear_parse();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(cfg_plan[ph]);
            if (ph == 0) begin
                push_str("-.5e+3i ", 1'b1, 1'b0);
                push_str("+e7", 1'b1, 1'b1);
                push_str("i ", 1'b1, 1'b0);
                push_str("x-?5", 1'b1, 1'b1);
                push_str("i", 1'b1, 1'b1);
                queue_char(8'hFF, 1'b1, 1'b0);
                queue_char(C_9, 1'b0, 1'b0);
                queue_char(8'h00, 1'b0, 1'b0);
                queue_char(C_9, 1'b0, 1'b1);
            end
            if (ph == 1) begin
                // overruns the output buffer and the position counter
                for (int k = 0; k < 70; k++)
                    queue_char(digit_char(), k == 0, k == 69);
            end
            while (n_items < (ph + 1) * PHASE_ITEMS)
                add_text();
            drain();
        end

        if (n_fail == 0)
            $display("number_token_extractor_unit: match");
        else
            $display("number_token_extractor_unit: mismatch");
        $finish;
    end

endmodule
